FILE: rtl/core/rpn_pkg.sv
// shared types and constants of the reverse polish stack evaluator
package rpn_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);

  // data path
  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam logic [3:0] MAX_DIGIT = 4'd9;

  // token opcodes
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_END  = 3'd5
  } opcode_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_BADFINAL  = 3'd4
  } status_e;

  // input request
  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] digit;
  } in_t;

  // result request
  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic               done_res;
  } out_t;

endpackage

FILE: rtl/core/rpn_stack_evaluator.sv
// reverse polish integer evaluator with a memory stack and a shared iterative unit
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (opcode, digit)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (value, status, done_res)
//
// push, end, ignored and error-blocked tokens go from idle straight to the done state;
// add, subtract and multiply read the left operand from stack memory and finish in exec.
// divide: the shared adder runs one restoring quotient bit per cycle over all 32 bits
// and then negates the quotient when the signs differ; a zero divisor is rejected in exec.
// reset clears the stack count, the sticky error and the result register valid.
// one token is in work at a time; a result waits in the output register under stall
// and the next token is taken as soon as the current one has left for that register.
module rpn_stack_evaluator
  import rpn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DIV  = 6'b000100,
    S_FIX  = 6'b001000,
    S_DONE = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  status_e sticky_q, sticky_d;
  logic out_valid_q, out_valid_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;

  logic [DATA_W-1:0] top_q, top_d;
  in_t tok_q, tok_d;
  logic is_end_q, is_end_d;
  logic [DATA_W-1:0] end_val_q, end_val_d;
  status_e end_st_q, end_st_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic neg_q, neg_d;
  out_t out_data_q;

  // stack memory
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic              rd_en;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [PTR_W-1:0]  lhs_addr;

  // shared adder
  logic [DATA_W+1:0] add_a, add_b, add_sum;
  logic              add_sub;

  logic [DATA_W-1:0] lhs, rhs, mul_lo, res, lhs_mag, rhs_mag, push_val;
  logic accept, out_load;
  out_t out_next;

  assign lhs      = rd_q;
  assign rhs      = top_q;
  assign lhs_addr = PTR_W'(count_q - CNT_W'(2));
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // operand magnitudes for the divider and the saturated push digit
  assign lhs_mag  = lhs[DATA_W-1] ? (~lhs + DATA_W'(1)) : lhs;
  assign rhs_mag  = rhs[DATA_W-1] ? (~rhs + DATA_W'(1)) : rhs;
  assign push_val = DATA_W'((in_data_i.digit > MAX_DIGIT) ? MAX_DIGIT : in_data_i.digit);

  // low half product, registered into the top of stack
  assign mul_lo = DATA_W'(lhs * rhs);

  // shared add, subtract, trial subtract and quotient negate
  always_comb begin
    add_a   = {2'b00, lhs};
    add_b   = {2'b00, rhs};
    add_sub = (tok_q.opcode == OP_SUB);
    if (state_q == S_DIV) begin
      add_a   = {1'b0, rem_q, quo_q[DATA_W-1]};
      add_b   = {2'b00, den_q};
      add_sub = 1'b1;
    end else if (state_q == S_FIX) begin
      add_a   = '0;
      add_b   = {2'b00, quo_q};
      add_sub = 1'b1;
    end
    add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(DATA_W+1){1'b0}}, add_sub};
  end

  // sequencer and data path next state
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    sticky_d  = sticky_q;
    div_cnt_d = div_cnt_q;
    top_d     = top_q;
    tok_d     = tok_q;
    is_end_d  = is_end_q;
    end_val_d = end_val_q;
    end_st_d  = end_st_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    den_d     = den_q;
    neg_d     = neg_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    res       = quo_q;
    wr_addr   = lhs_addr;
    wr_data   = res;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          tok_d    = in_data_i;
          is_end_d = (in_data_i.opcode == OP_END);
          state_d  = S_DONE;
          if (in_data_i.opcode == OP_END) begin
            // final report, then the stack and the error clear
            if (sticky_q != ST_OK) begin
              end_st_d = sticky_q;
            end else if (count_q != CNT_W'(1)) begin
              end_st_d = ST_BADFINAL;
            end else begin
              end_st_d = ST_OK;
            end
            end_val_d = ((sticky_q == ST_OK) && (count_q == CNT_W'(1))) ? top_q : '0;
            count_d   = '0;
            sticky_d  = ST_OK;
          end else if (sticky_q == ST_OK) begin
            unique case (in_data_i.opcode) inside
              OP_PUSH: begin
                if (count_q >= CNT_W'(STACK_DEPTH)) begin
                  sticky_d = ST_OVERFLOW;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = count_q[PTR_W-1:0];
                  wr_data = push_val;
                  top_d   = push_val;
                  count_d = count_q + CNT_W'(1);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (count_q < CNT_W'(2)) begin
                  sticky_d = ST_UNDERFLOW;
                end else begin
                  rd_en   = 1'b1;
                  state_d = S_EXEC;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        unique case (tok_q.opcode) inside
          OP_ADD, OP_SUB, OP_MUL: begin
            res     = (tok_q.opcode == OP_MUL) ? mul_lo : add_sum[DATA_W-1:0];
            wr_en   = 1'b1;
            wr_data = res;
            top_d   = res;
            count_d = count_q - CNT_W'(1);
            state_d = S_DONE;
          end
          default: begin
            // divide: reject a zero divisor, else load the iterative unit
            if (rhs == '0) begin
              sticky_d = ST_DIVZERO;
              state_d  = S_DONE;
            end else begin
              rem_d     = '0;
              quo_d     = lhs_mag;
              den_d     = rhs_mag;
              neg_d     = lhs[DATA_W-1] ^ rhs[DATA_W-1];
              div_cnt_d = '0;
              state_d   = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        // one restoring quotient bit a cycle
        if (!add_sum[DATA_W+1]) begin
          rem_d = add_sum[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DCNT_W'(1);
        if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        res     = neg_q ? add_sum[DATA_W-1:0] : quo_q;
        wr_en   = 1'b1;
        wr_data = res;
        top_d   = res;
        count_d = count_q - CNT_W'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result assembly
  always_comb begin
    if (is_end_q) begin
      out_next.value    = end_val_q;
      out_next.status   = end_st_q;
      out_next.done_res = 1'b1;
    end else begin
      out_next.value    = (count_q != '0) ? top_q : '0;
      out_next.status   = sticky_q;
      out_next.done_res = 1'b0;
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sticky_q    <= ST_OK;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // data path registers
  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    tok_q     <= tok_d;
    is_end_q  <= is_end_d;
    end_val_q <= end_val_d;
    end_st_q  <= end_st_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    if (out_load) begin
      out_data_q <= out_next;
    end
  end

  // stack memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= stack_mem[lhs_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: tb/tb_rpn_stack_evaluator.sv
// testbench for the reverse polish stack evaluator: directed and random token streams
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;
  import rpn_pkg::*;

  // spare opcodes that the block ignores
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int TAIL_CYCLES  = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // evaluator state as the predictor sees it
  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_depth = 0;
  status_e     calc_err = ST_OK;

  out_t answer_q [$];
  int   mismatches = 0;
  int   sent_tokens = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;

  rpn_stack_evaluator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // compute the answer of one token and advance the evaluator state
  function automatic out_t eval_token(input in_t tok);
    out_t        res;
    logic [31:0] lhs, rhs, mag_l, mag_r, quot;
    res = '0;
    if (tok.opcode == OP_END) begin
      if (calc_err != ST_OK) begin
        res.status = calc_err;
      end else if (calc_depth != 1) begin
        res.status = ST_BADFINAL;
      end else begin
        res.value = calc_stack[0];
      end
      calc_depth   = 0;
      calc_err     = ST_OK;
      res.done_res = 1'b1;
    end else begin
      if (calc_err == ST_OK) begin
        case (tok.opcode)
          OP_PUSH: begin
            if (calc_depth >= STACK_DEPTH) begin
              calc_err = ST_OVERFLOW;
            end else begin
              // digits above nine saturate
              calc_stack[calc_depth] = 32'((tok.digit > MAX_DIGIT) ? MAX_DIGIT : tok.digit);
              calc_depth++;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (calc_depth < 2) begin
              calc_err = ST_UNDERFLOW;
            end else begin
              rhs = calc_stack[calc_depth - 1];
              lhs = calc_stack[calc_depth - 2];
              if (tok.opcode == OP_DIV && rhs == '0) begin
                calc_err = ST_DIVZERO;
              end else begin
                case (tok.opcode)
                  OP_ADD: quot = lhs + rhs;
                  OP_SUB: quot = lhs - rhs;
                  OP_MUL: quot = lhs * rhs;
                  default: begin
                    // truncating signed divide on magnitudes
                    mag_l = lhs[31] ? -lhs : lhs;
                    mag_r = rhs[31] ? -rhs : rhs;
                    quot  = mag_l / mag_r;
                    if (lhs[31] ^ rhs[31]) quot = -quot;
                  end
                endcase
                calc_depth--;
                calc_stack[calc_depth - 1] = quot;
              end
            end
          end
          default: ;
        endcase
      end
      res.value  = (calc_depth == 0) ? '0 : calc_stack[calc_depth - 1];
      res.status = calc_err;
    end
    return res;
  endfunction

  // send one token request, with random gaps, and record its answer
  task automatic send_token(input logic [2:0] op, input logic [3:0] dig);
    in_t tok;
    tok.opcode = op;
    tok.digit  = dig;
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_tokens++;
    answer_q.push_back(eval_token(tok));
    @(negedge clk);
  endtask

  // hold off until every answer has come back
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    @(negedge clk);
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  // random well-formed expression over n operands
  task automatic send_expression(input int n);
    int         left;
    int         depth;
    logic [2:0] op;
    left  = n;
    depth = 0;
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || $urandom_range(1) == 1)) begin
        case ($urandom_range(9))
          0, 1:    op = OP_ADD;
          2, 3:    op = OP_SUB;
          8, 9:    op = OP_DIV;
          default: op = OP_MUL;
        endcase
        send_token(op, 4'($urandom_range(15)));
        depth--;
      end else begin
        send_token(OP_PUSH, 4'(($urandom_range(9) == 0) ? $urandom_range(15, 10)
                                                        : $urandom_range(9)));
        depth++;
        left--;
      end
      if ($urandom_range(49) == 0) begin
        send_token($urandom_range(1) ? OP_SPARE7 : OP_SPARE6, 4'($urandom_range(15)));
      end
    end
    send_token(OP_END, 4'($urandom_range(15)));
  endtask

  // each operator on well-formed input, digit saturation, negative quotient
  task automatic test_basic_ops();
    send_token(OP_PUSH, 4'd7);
    send_token(OP_PUSH, 4'd2);
    send_token(OP_SUB, 4'd0);
    send_token(OP_PUSH, 4'd6);
    send_token(OP_MUL, 4'd15);
    send_token(OP_PUSH, 4'd4);
    send_token(OP_ADD, 4'd0);
    send_token(OP_PUSH, 4'd7);
    send_token(OP_DIV, 4'd0);
    send_token(OP_END, 4'd0);
    // (0 - 15 saturated) / 2 truncates toward zero
    send_token(OP_PUSH, 4'd0);
    send_token(OP_PUSH, 4'd15);
    send_token(OP_SUB, 4'd0);
    send_token(OP_PUSH, 4'd2);
    send_token(OP_DIV, 4'd0);
    send_token(OP_SPARE6, 4'd0);
    send_token(OP_END, 4'd15);
  endtask

  // underflow, divide by zero, ignored tokens after an error, bad final stack
  task automatic test_error_cases();
    send_token(OP_END, 4'd0);
    send_token(OP_PUSH, 4'd1);
    send_token(OP_ADD, 4'd0);
    send_token(OP_PUSH, 4'd3);
    send_token(OP_END, 4'd0);
    send_token(OP_PUSH, 4'd5);
    send_token(OP_PUSH, 4'd0);
    send_token(OP_DIV, 4'd0);
    send_token(OP_SPARE7, 4'd9);
    send_token(OP_END, 4'd0);
    send_token(OP_PUSH, 4'd9);
    send_token(OP_PUSH, 4'd9);
    send_token(OP_END, 4'd0);
  endtask

  // most negative value divided by minus one wraps
  task automatic test_min_div();
    send_token(OP_PUSH, 4'd8);
    repeat (9) begin
      send_token(OP_PUSH, 4'd8);
      send_token(OP_MUL, 4'd0);
    end
    send_token(OP_PUSH, 4'd2);
    send_token(OP_MUL, 4'd0);
    send_token(OP_PUSH, 4'd0);
    send_token(OP_PUSH, 4'd1);
    send_token(OP_SUB, 4'd0);
    send_token(OP_DIV, 4'd0);
    send_token(OP_END, 4'd0);
  endtask

  // mostly well-formed expressions, some noise and unterminated runs
  task automatic test_random();
    int len;
    while (sent_tokens < RANDOM_ITEMS) begin
      quiet = (sent_tokens >= 450 && sent_tokens < 700);
      if ($urandom_range(99) < 75) begin
        send_expression(($urandom_range(99) < 12) ? $urandom_range(18, 12) : $urandom_range(8, 1));
      end else begin
        len = $urandom_range(12, 1);
        repeat (len) send_token(3'($urandom_range(7)), 4'($urandom_range(15)));
        if ($urandom_range(1) == 1) send_token(OP_END, 4'($urandom_range(15)));
      end
      if ($urandom_range(19) == 0) wait_for_answers();
    end
    quiet = 1'b0;
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 20);
  end

  // compare each accepted result with the oldest expected answer
  always @(posedge clk) begin
    out_t want;
    if (out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $error("result with no answer pending: value %0d status %0d done %0b",
               out_data.value, out_data.status, out_data.done_res);
        mismatches++;
      end else begin
        want = answer_q.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, out_data.value);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.done_res !== want.done_res) begin
          $error("done_res: expected %0b, actual %0b", want.done_res, out_data.done_res);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_basic_ops();
    wait_for_answers();
    test_error_cases();
    wait_for_answers();
    test_min_div();
    wait_for_answers();
    test_random();
    wait_for_answers();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_stack_evaluator.sv
tb/tb_rpn_stack_evaluator.sv
